>>> sv/icp_pkg.sv
// ----------------------------------------------------------------------------
// icp_pkg
// Shared sizes, codes and controller/datapath bundles of the coverage pileup.
// ----------------------------------------------------------------------------
package icp_pkg;

  // Ring size and the widths that follow from it.
  localparam int unsigned Window = 64;
  localparam int unsigned AddrW  = $clog2(Window);
  localparam int unsigned FillW  = $clog2(Window + 1);

  // Fixed field widths.
  localparam int unsigned PosW   = 31;
  localparam int unsigned DepthW = 16;

  // Request codes.
  typedef enum logic {
    REQ_ADD   = 1'b0,
    REQ_FLUSH = 1'b1
  } req_type_e;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RETIRE,
    ST_RET_EVAL,
    ST_PREP,
    ST_INC_RD,
    ST_INC_WR,
    ST_FINISH,
    ST_DROP
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic ret_rd;
    logic retire;
    logic capture;
    logic head_clr;
    logic seq_set;
    logic prep;
    logic inc_rd;
    logic inc_wr;
    logic fin_push;
    logic err_push;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_flush;
    logic drop;
    logic same_seq;
    logic fill_nz;
    logic head_lt_b;
    logic depth_nz;
    logic pend_valid;
    logic out_free;
    logic inc_done;
  } sts_t;

  // Ring index plus offset, modulo the ring size.
  function automatic logic [AddrW-1:0] ring_add(input logic [AddrW-1:0] a,
                                                input logic [AddrW-1:0] b);
    logic [AddrW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (AddrW+1)'(Window)) begin
      sum = sum - (AddrW+1)'(Window);
    end
    return sum[AddrW-1:0];
  endfunction

  // Ring index plus one, modulo the ring size.
  function automatic logic [AddrW-1:0] ring_inc(input logic [AddrW-1:0] a);
    logic [AddrW-1:0] nxt;
    nxt = (a == AddrW'(Window - 1)) ? '0 : a + AddrW'(1);
    return nxt;
  endfunction

endpackage

>>> sv/icp_if.sv
// ----------------------------------------------------------------------------
// icp_req_if / icp_res_if
// Valid/ready channels carrying pileup requests and reported depths.
// ----------------------------------------------------------------------------
interface icp_req_if;
  import icp_pkg::*;

  logic            valid;
  logic            ready;
  logic            req_type;
  logic [PosW-1:0] seq_id;
  logic [PosW-1:0] start_pos;
  logic [PosW-1:0] stop_pos;

  modport source (output valid, req_type, seq_id, start_pos, stop_pos, input ready);
  modport sink   (input valid, req_type, seq_id, start_pos, stop_pos, output ready);
endinterface

interface icp_res_if;
  import icp_pkg::*;

  logic              valid;
  logic              ready;
  logic [PosW-1:0]   position;
  logic [DepthW-1:0] depth;
  logic              error;
  logic              last;

  modport source (output valid, position, depth, error, last, input ready);
  modport sink   (input valid, position, depth, error, last, output ready);
endinterface

>>> sv/interval_coverage_pileup_unit.sv
// ----------------------------------------------------------------------------
// interval_coverage_pileup_unit
// Sliding-window read-depth pileup over intervals sorted by start position.
//
// Requests arrive on req_i: add an interval (sequence id, first and last
// covered position) or flush. Reported depths leave on res_o as position and
// depth, with error set on a dropped interval and last on the final result
// of a request; a request that retires no covered position reports nothing.
// One request is handled at a time. An add request is accepted and checked,
// then retires ring positions one at a time (registered memory read, then
// evaluate and retire), ends retirement, sets up, and increments each
// covered position (read, then write back) before it finishes; the
// read-modify-write of the ring memory sets the pace. A flush retires every
// held position and finishes; a dropped interval is checked and reported.
// One result is held back until the next nonzero depth or the end of the
// request is known, so that last can be marked; the output register lets a
// new request be taken while a result still waits. A stalled receiver stops
// the retire sequence only when a further result has to be handed over.
// Reset clears the ring valid bits, pointers, sequence and both channels at
// once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module interval_coverage_pileup_unit (
  input logic       clk_i,
  input logic       rst_ni,
  icp_req_if.sink   req_i,
  icp_res_if.source res_o
);
  import icp_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic req_ready;

  // Sequencer.
  icp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  assign req_i.ready = req_ready;

  // Ring and result datapath.
  icp_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_type_i  (req_i.req_type),
    .seq_id_i    (req_i.seq_id),
    .start_pos_i (req_i.start_pos),
    .stop_pos_i  (req_i.stop_pos),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .position_o  (res_o.position),
    .depth_o     (res_o.depth),
    .error_o     (res_o.error),
    .last_o      (res_o.last)
  );

endmodule

>>> sv/icp_ctrl.sv
// ----------------------------------------------------------------------------
// icp_ctrl
// Sequencer for the pileup: checks a request, reports a dropped one, retires
// ring positions one at a time, then increments an add's covered positions.
// ----------------------------------------------------------------------------
module icp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  icp_pkg::sts_t sts_i,
  output icp_pkg::cmd_t cmd_o
);
  import icp_pkg::*;

  state_e state_q, state_d;
  logic   mode_all_q, mode_all_d;

  // State and mode registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      mode_all_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      mode_all_q <= mode_all_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    mode_all_d  = mode_all_q;
    cmd_o       = '0;
    req_ready_o = (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.req_flush) begin
          mode_all_d = 1'b1;
          state_d    = ST_RETIRE;
        end else if (sts_i.drop) begin
          state_d = ST_DROP;
        end else begin
          // A new sequence empties the whole ring first.
          mode_all_d = !sts_i.same_seq;
          state_d    = ST_RETIRE;
        end
      end
      ST_RETIRE: begin
        if (sts_i.fill_nz && (mode_all_q || sts_i.head_lt_b)) begin
          cmd_o.ret_rd = 1'b1;
          state_d      = ST_RET_EVAL;
        end else if (mode_all_q) begin
          cmd_o.head_clr = 1'b1;
          if (sts_i.req_flush) begin
            state_d = ST_FINISH;
          end else begin
            cmd_o.seq_set = 1'b1;
            state_d       = ST_PREP;
          end
        end else begin
          state_d = ST_PREP;
        end
      end
      ST_RET_EVAL: begin
        // A nonzero depth waits until the held result can move on.
        if (!sts_i.depth_nz) begin
          cmd_o.retire = 1'b1;
          state_d      = ST_RETIRE;
        end else if (!sts_i.pend_valid || sts_i.out_free) begin
          cmd_o.capture = 1'b1;
          cmd_o.retire  = 1'b1;
          state_d       = ST_RETIRE;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_INC_RD;
      end
      ST_INC_RD: begin
        cmd_o.inc_rd = 1'b1;
        state_d      = ST_INC_WR;
      end
      ST_INC_WR: begin
        cmd_o.inc_wr = 1'b1;
        state_d      = sts_i.inc_done ? ST_FINISH : ST_INC_RD;
      end
      ST_FINISH: begin
        if (!sts_i.pend_valid) begin
          state_d = ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.fin_push = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_DROP: begin
        if (sts_i.out_free) begin
          cmd_o.err_push = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> sv/icp_datapath.sv
// ----------------------------------------------------------------------------
// icp_datapath
// Depth ring memory with per-entry valid bits, ring pointers, request
// registers, a one-deep hold for the latest depth and the output register.
// ----------------------------------------------------------------------------
module icp_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  icp_pkg::cmd_t               cmd_i,
  output icp_pkg::sts_t               sts_o,
  input  logic                        req_type_i,
  input  logic [icp_pkg::PosW-1:0]    seq_id_i,
  input  logic [icp_pkg::PosW-1:0]    start_pos_i,
  input  logic [icp_pkg::PosW-1:0]    stop_pos_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output logic [icp_pkg::PosW-1:0]    position_o,
  output logic [icp_pkg::DepthW-1:0]  depth_o,
  output logic                        error_o,
  output logic                        last_o
);
  import icp_pkg::*;

  logic              req_flush_q;
  logic [PosW-1:0]   seq_q, start_q, stop_q;

  logic [DepthW-1:0] ring_mem [Window];
  logic [Window-1:0] vld_q;
  logic [AddrW-1:0]  head_idx_q, k_q, addr_q, rd_addr;
  logic [FillW-1:0]  fill_q, span_fill;
  logic [PosW-1:0]   head_pos_q, cur_seq_q;
  logic              seq_valid_q;
  logic [DepthW-1:0] rd_q, cur_depth, inc_depth;
  logic [PosW-1:0]   diff;
  logic [AddrW-1:0]  span;
  logic              same_seq, fill_nz, out_free, push;

  logic              pend_valid_q;
  logic [PosW-1:0]   pend_pos_q;
  logic [DepthW-1:0] pend_depth_q;

  logic              out_valid_q;
  logic [PosW-1:0]   out_pos_q;
  logic [DepthW-1:0] out_depth_q;
  logic              out_err_q, out_last_q;

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_flush_q <= (req_type_i == REQ_FLUSH);
      seq_q       <= seq_id_i;
      start_q     <= start_pos_i;
      stop_q      <= stop_pos_i;
    end
  end

  // Checks on the held request.
  assign diff      = stop_q - start_q;
  assign span      = diff[AddrW-1:0];
  assign span_fill = {1'b0, span} + FillW'(1);
  assign same_seq  = seq_valid_q && (seq_q == cur_seq_q);
  assign fill_nz   = (fill_q != '0);

  // Ring memory: one read and one write port, registered read.
  assign rd_addr = cmd_i.ret_rd ? head_idx_q : ring_add(head_idx_q, k_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.inc_wr) begin
      ring_mem[addr_q] <= inc_depth;
    end
    if (cmd_i.ret_rd || cmd_i.inc_rd) begin
      rd_q   <= ring_mem[rd_addr];
      addr_q <= rd_addr;
    end
  end

  // An entry without its valid bit reads as zero.
  assign cur_depth = vld_q[addr_q] ? rd_q : '0;
  assign inc_depth = (&cur_depth) ? cur_depth : cur_depth + DepthW'(1);

  // Ring pointers, fill count and valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      head_idx_q <= '0;
      head_pos_q <= '0;
      fill_q     <= '0;
      k_q        <= '0;
    end else if (cmd_i.retire) begin
      vld_q[addr_q] <= 1'b0;
      head_idx_q    <= ring_inc(head_idx_q);
      head_pos_q    <= head_pos_q + PosW'(1);
      fill_q        <= fill_q - FillW'(1);
    end else if (cmd_i.head_clr) begin
      head_pos_q <= '0;
    end else if (cmd_i.prep) begin
      if (!fill_nz) begin
        head_pos_q <= start_q;
      end
      if (span_fill > fill_q) begin
        fill_q <= span_fill;
      end
      k_q <= '0;
    end else if (cmd_i.inc_wr) begin
      vld_q[addr_q] <= 1'b1;
      if (k_q != span) begin
        k_q <= k_q + AddrW'(1);
      end
    end
  end

  // Current sequence.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_seq_q   <= '0;
      seq_valid_q <= 1'b0;
    end else if (cmd_i.seq_set) begin
      cur_seq_q   <= seq_q;
      seq_valid_q <= 1'b1;
    end
  end

  // Result hold and output register control.
  assign out_free = !out_valid_q || res_ready_i;
  assign push     = (cmd_i.capture && pend_valid_q) || cmd_i.fin_push || cmd_i.err_push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.fin_push) begin
        pend_valid_q <= 1'b0;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payloads.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pend_pos_q   <= head_pos_q;
      pend_depth_q <= cur_depth;
    end
    if (cmd_i.err_push) begin
      out_pos_q   <= start_q;
      out_depth_q <= '0;
      out_err_q   <= 1'b1;
      out_last_q  <= 1'b1;
    end else if (push) begin
      out_pos_q   <= pend_pos_q;
      out_depth_q <= pend_depth_q;
      out_err_q   <= 1'b0;
      out_last_q  <= cmd_i.fin_push;
    end
  end

  assign res_valid_o = out_valid_q;
  assign position_o  = out_pos_q;
  assign depth_o     = out_depth_q;
  assign error_o     = out_err_q;
  assign last_o      = out_last_q;

  // Status towards the controller.
  always_comb begin
    sts_o            = '0;
    sts_o.req_flush  = req_flush_q;
    sts_o.drop       = (stop_q < start_q) || (diff >= PosW'(Window)) ||
                       (same_seq && fill_nz && (start_q < head_pos_q));
    sts_o.same_seq   = same_seq;
    sts_o.fill_nz    = fill_nz;
    sts_o.head_lt_b  = (head_pos_q < start_q);
    sts_o.depth_nz   = (cur_depth != '0);
    sts_o.pend_valid = pend_valid_q;
    sts_o.out_free   = out_free;
    sts_o.inc_done   = (k_q == span);
  end

endmodule

>>> sv/icp_checker.sv
// ----------------------------------------------------------------------------
// icp_checker
// Port-level checks on the pileup unit, bound to its top level.
// ----------------------------------------------------------------------------
module icp_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_valid_i,
  input logic                       req_ready_i,
  input logic                       res_valid_i,
  input logic                       res_ready_i,
  input logic [icp_pkg::PosW-1:0]   position_i,
  input logic [icp_pkg::DepthW-1:0] depth_i,
  input logic                       error_i,
  input logic                       last_i
);
  import icp_pkg::*;

  // A stalled result keeps its valid.
  a_res_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result valid dropped while stalled");

  // A stalled result keeps its payload.
  a_res_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(position_i) && $stable(depth_i) &&
                                    $stable(error_i) && $stable(last_i))
    else $error("result payload changed while stalled");

  // A request is worked on alone: no second one in the next cycle.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken back to back");

  // A dropped interval is reported alone, with zero depth.
  a_drop_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && error_i |-> (depth_i == '0) && last_i)
    else $error("malformed drop report");

  // Only positions with coverage are reported.
  a_depth_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !error_i |-> (depth_i != '0))
    else $error("zero depth reported");

endmodule

bind interval_coverage_pileup_unit icp_checker u_icp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .position_i  (res_o.position),
  .depth_i     (res_o.depth),
  .error_i     (res_o.error),
  .last_i      (res_o.last)
);
